FILE: sv/ema_value_and_slope_tracker_unit_assert.svh
// Assertion macros shared by the checker of the EMA value and slope tracker.
`ifndef EMA_VALUE_AND_SLOPE_TRACKER_UNIT_ASSERT_SVH
`define EMA_VALUE_AND_SLOPE_TRACKER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define EVST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker assertion failed");

// Consequent checked in the cycle after the antecedent.
`define EVST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker assertion failed");

`endif

FILE: sv/evst_pkg.sv
// Package with widths, register indexes, control types and states of the tracker.
`timescale 1ns / 1ps

package evst_pkg;

   localparam int TICKS_PER_SECOND = 1000;

   localparam int DATA_W    = 32;
   localparam int WEIGHT_W  = 17;
   localparam int WGT_FRAC  = 16;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int TICKS_W   = $clog2(TICKS_PER_SECOND + 1);
   localparam int MAG_W     = DIFF_W + TICKS_W;
   localparam int CNT_W     = $clog2(MAG_W + 1);
   localparam int PROD_W    = DIFF_W + WEIGHT_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = WEIGHT_W'(1 << WGT_FRAC);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = WEIGHT_W'(58982);
   localparam logic [CNT_W-1:0]    DIV_LAST       = CNT_W'(MAG_W - 1);
   localparam logic [DATA_W-1:0]   RATE_MAX       = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0]   RATE_MIN       = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [PROD_W-1:0]   ROUND_HALF     = PROD_W'(1 << (WGT_FRAC - 1));

   localparam logic [CSR_IDX_W-1:0] REG_VALUE_SMOOTHING     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE_SMOOTHING     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE_FROM_SMOOTHED = 2'd2;

   typedef struct packed {
      logic load;
      logic vmul;
      logic vfin;
      logic scale;
      logic div_step;
      logic sat;
      logic smul;
      logic sfin;
      logic commit;
   } evst_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic zero_elapsed;
   } evst_sts_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_VMUL  = 9'b000000010,
      S_VFIN  = 9'b000000100,
      S_SCALE = 9'b000001000,
      S_DIV   = 9'b000010000,
      S_SAT   = 9'b000100000,
      S_SMUL  = 9'b001000000,
      S_SFIN  = 9'b010000000,
      S_WRITE = 9'b100000000
   } evst_state_type;

endpackage

FILE: sv/evst_if.sv
// Channel interfaces of the tracker: sample requests, results and register writes.
`timescale 1ns / 1ps

interface evst_req_if import evst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [DATA_W-1:0] sample;
   logic [DATA_W-1:0] now_ms;

   modport source (output valid, mode, sample, now_ms, input ready);
   modport sink (input valid, mode, sample, now_ms, output ready);
   modport monitor (input valid, ready, mode, sample, now_ms);
endinterface

interface evst_rsp_if import evst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] smoothed_value;
   logic [DATA_W-1:0] smoothed_slope;
   logic              zero_interval;

   modport source (output valid, smoothed_value, smoothed_slope, zero_interval, input ready);
   modport sink (input valid, smoothed_value, smoothed_slope, zero_interval, output ready);
   modport monitor (input valid, ready, smoothed_value, smoothed_slope, zero_interval);
endinterface

interface evst_csr_if import evst_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WEIGHT_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

FILE: sv/evst_datapath.sv
// Datapath of the tracker: state, settings, shared multiplier, divider and result register.
`timescale 1ns / 1ps

module evst_datapath import evst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  evst_cmd_type         cmd,
   output evst_sts_type         sts,
   input  logic                 in_mode,
   input  logic [DATA_W-1:0]    in_sample,
   input  logic [DATA_W-1:0]    in_now_ms,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WEIGHT_W-1:0]  csr_data,
   output logic [DATA_W-1:0]    out_value,
   output logic [DATA_W-1:0]    out_slope,
   output logic                 out_flag
);

   // Settings and tracked state.
   logic [WEIGHT_W-1:0] vsm_ff, ssm_ff;
   logic                from_sm_ff;
   logic [DATA_W-1:0]   value_ff, slope_ff, last_ff;

   // Item and working registers.
   logic                mode_ff;
   logic [DATA_W-1:0]   sample_ff, now_ff, elapsed_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [DATA_W-1:0]   nv_ff, rate_ff, slope_res_ff;
   logic                neg_ff;
   logic [MAG_W-1:0]    quo_ff;
   logic [DATA_W-1:0]   rem_ff;
   logic [DATA_W-1:0]   out_value_ff, out_slope_ff;
   logic                out_flag_ff;

   logic [WEIGHT_W-1:0]      csr_weight;
   logic signed [DIFF_W-1:0] mul_a;
   logic signed [WEIGHT_W:0] mul_w;
   logic signed [PROD_W-1:0] prod_in;
   logic [DATA_W-1:0]        blend_base;
   logic [PROD_W-1:0]        blend_acc;
   logic [DATA_W-1:0]        blend_res;
   logic [DATA_W-1:0]        target;
   logic [DIFF_W-1:0]        diff;
   logic [DIFF_W-1:0]        mag;
   logic [MAG_W-1:0]         mag_scaled;
   logic [DIFF_W-1:0]        shifted;
   logic [DIFF_W-1:0]        trial;
   logic                     fits;
   logic                     big;
   logic [DATA_W-1:0]        rate_in;
   logic [DATA_W-1:0]        new_value, new_slope;
   logic                     new_flag;

   assign sts.is_clear     = mode_ff;
   assign sts.zero_elapsed = (elapsed_ff == '0);

   assign csr_weight = (csr_data > WEIGHT_ONE) ? WEIGHT_ONE : csr_data;

   // One multiplier serves both blends: (old - new) * weight.
   always_comb begin
      if (cmd.smul) begin
         mul_a = $signed({slope_ff[DATA_W-1], slope_ff}) - $signed({rate_ff[DATA_W-1], rate_ff});
         mul_w = $signed({1'b0, ssm_ff});
      end else begin
         mul_a = $signed({value_ff[DATA_W-1], value_ff})
               - $signed({sample_ff[DATA_W-1], sample_ff});
         mul_w = $signed({1'b0, vsm_ff});
      end
      prod_in = mul_a * mul_w;
   end

   // Blend finish: new * 2^16 plus the product plus one half, then floor by 2^16.
   assign blend_base = cmd.sfin ? rate_ff : sample_ff;
   assign blend_acc  = {{(PROD_W-DATA_W-WGT_FRAC){blend_base[DATA_W-1]}}, blend_base,
                        {WGT_FRAC{1'b0}}} + prod_ff + ROUND_HALF;
   assign blend_res  = blend_acc[WGT_FRAC+DATA_W-1:WGT_FRAC];

   // Slope numerator magnitude, scaled to ticks per second.
   assign target     = from_sm_ff ? nv_ff : sample_ff;
   assign diff       = {target[DATA_W-1], target} - {value_ff[DATA_W-1], value_ff};
   assign mag        = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
   assign mag_scaled = MAG_W'(mag) * MAG_W'(TICKS_PER_SECOND);

   // One restoring division step per cycle.
   assign shifted = {rem_ff, quo_ff[MAG_W-1]};
   assign trial   = shifted - {1'b0, elapsed_ff};
   assign fits    = (shifted >= {1'b0, elapsed_ff});

   // Saturation of the quotient to the signed 32-bit range.
   always_comb begin
      big = |quo_ff[MAG_W-1:DATA_W-1];
      if (neg_ff) begin
         rate_in = big ? RATE_MIN : (~quo_ff[DATA_W-1:0] + 1'b1);
      end else begin
         rate_in = big ? RATE_MAX : quo_ff[DATA_W-1:0];
      end
   end

   always_comb begin
      if (mode_ff) begin
         new_value = '0;
         new_slope = '0;
         new_flag  = 1'b0;
      end else begin
         new_value = nv_ff;
         new_slope = sts.zero_elapsed ? slope_ff : slope_res_ff;
         new_flag  = sts.zero_elapsed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vsm_ff     <= WEIGHT_RESET;
         ssm_ff     <= WEIGHT_RESET;
         from_sm_ff <= 1'b0;
         value_ff   <= '0;
         slope_ff   <= '0;
         last_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_VALUE_SMOOTHING:     vsm_ff     <= csr_weight;
               REG_SLOPE_SMOOTHING:     ssm_ff     <= csr_weight;
               REG_SLOPE_FROM_SMOOTHED: from_sm_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.commit) begin
            value_ff <= new_value;
            slope_ff <= new_slope;
            last_ff  <= now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= in_mode;
         sample_ff  <= in_sample;
         now_ff     <= in_now_ms;
         elapsed_ff <= in_now_ms - last_ff;
      end
      if (cmd.vmul || cmd.smul) begin
         prod_ff <= prod_in;
      end
      if (cmd.vfin) begin
         nv_ff <= blend_res;
      end
      if (cmd.sfin) begin
         slope_res_ff <= blend_res;
      end
      if (cmd.scale) begin
         quo_ff <= mag_scaled;
         rem_ff <= '0;
         neg_ff <= diff[DIFF_W-1];
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[MAG_W-2:0], fits};
         rem_ff <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      end
      if (cmd.sat) begin
         rate_ff <= rate_in;
      end
      if (cmd.commit) begin
         out_value_ff <= new_value;
         out_slope_ff <= new_slope;
         out_flag_ff  <= new_flag;
      end
   end

   assign out_value = out_value_ff;
   assign out_slope = out_slope_ff;
   assign out_flag  = out_flag_ff;

endmodule

FILE: sv/evst_ctrl.sv
// Controller of the tracker: sequences one item through the datapath and owns the handshakes.
`timescale 1ns / 1ps

module evst_ctrl import evst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  evst_sts_type sts,
   output evst_cmd_type cmd
);

   evst_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_VMUL;
            end
         end
         S_VMUL: begin
            cmd.vmul = 1'b1;
            state_in = sts.is_clear ? S_WRITE : S_VFIN;
         end
         S_VFIN: begin
            cmd.vfin = 1'b1;
            state_in = sts.zero_elapsed ? S_WRITE : S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            cnt_in    = '0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            cmd.sat  = 1'b1;
            state_in = S_SMUL;
         end
         S_SMUL: begin
            cmd.smul = 1'b1;
            state_in = S_SFIN;
         end
         S_SFIN: begin
            cmd.sfin = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/ema_value_and_slope_tracker_unit.sv
// Top level of the EMA value and slope tracker: controller, datapath and channel wiring.
`timescale 1ns / 1ps
//
//   Channel   Direction  Beat carries
//   req_bus   in         mode, sample (Q16.16), now_ms
//   rsp_bus   out        smoothed_value, smoothed_slope, zero_interval
//   csr_bus   in         index, data (register write)
//
// An update beat spends most of its time in the 43-step restoring divider, one
// quotient bit per cycle. A beat whose elapsed time is zero skips the division and
// the slope blend; a clear beat also skips the value blend.
// Reset is synchronous; it restores the smoothing weights to 58982 and zeroes state.
// A stalled result beat waits in the output register while the next request is
// taken; that request only stalls in its last step if the result is still unread.

module ema_value_and_slope_tracker_unit import evst_pkg::*; (
   input logic       clock,
   input logic       reset,
   evst_req_if.sink  req_bus,
   evst_rsp_if.source rsp_bus,
   evst_csr_if.sink  csr_bus
);

   evst_cmd_type cmd;
   evst_sts_type sts;

   // Register writes must arrive only while the block is idle (not enforced); no stall.
   assign csr_bus.ready = 1'b1;

   // The controller walks a full update through multiply, blend, scale, divide,
   // saturate and a second blend; the datapath holds every value involved.
   evst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Stored state and the output register are updated together when the
   // result beat is loaded, so a waiting result never sees a half-updated item.
   evst_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_mode   (req_bus.mode),
      .in_sample (req_bus.sample),
      .in_now_ms (req_bus.now_ms),
      .csr_we    (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .out_value (rsp_bus.smoothed_value),
      .out_slope (rsp_bus.smoothed_slope),
      .out_flag  (rsp_bus.zero_interval)
   );

endmodule

FILE: sv/evst_checker.sv
// Port-level checker of the tracker and its bind to the top level.
`timescale 1ns / 1ps
`include "ema_value_and_slope_tracker_unit_assert.svh"

module evst_checker import evst_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_value,
   input logic [DATA_W-1:0] rsp_slope,
   input logic              rsp_flag,
   input logic              csr_valid,
   input logic              csr_ready
);

   // A stalled result beat keeps its payload.
   `EVST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_slope) && $stable(rsp_flag))

   // One item at a time: an accepted request leaves the block busy next cycle.
   `EVST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // A new result beat is only produced by a busy block.
   `EVST_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // Register writes are never stalled.
   `EVST_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind ema_value_and_slope_tracker_unit evst_checker u_evst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.smoothed_value),
   .rsp_slope (rsp_bus.smoothed_slope),
   .rsp_flag  (rsp_bus.zero_interval),
   .csr_valid (csr_bus.valid),
   .csr_ready (csr_bus.ready)
);
